@@ rtl/b64e_pkg.sv @@
// ----------------------------------------------------------------------------
// b64e_pkg
// Types, constants and the alphabet lookup shared by the Base64 encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int GPL_W      = 6;

    // register index, taken from paddr[2]
    localparam logic REG_GROUPS_PER_LINE = 1'b0;

    localparam logic [GPL_W-1:0] GPL_RESET = 6'd19;

    localparam logic [7:0] CHAR_PAD = 8'd61;
    localparam logic [7:0] CHAR_CR  = 8'd13;
    localparam logic [7:0] CHAR_LF  = 8'd10;

    // one encoding job handed from the front to the back
    typedef struct packed {
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [1:0] pads;    // number of '=' in the four characters
        logic       crlf;    // line break follows the group
        logic       last;    // job ends the message
    } job_t;

    function automatic logic [7:0] b64e_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26)
        begin
            c = {2'b00, v} + 8'd65;
        end
        else if (v < 6'd52)
        begin
            c = {2'b00, v} + 8'd71;
        end
        else if (v < 6'd62)
        begin
            c = {2'b00, v} - 8'd4;
        end
        else if (v == 6'd62)
        begin
            c = 8'd43;
        end
        else
        begin
            c = 8'd47;
        end
        return c;
    endfunction

endpackage

@@ rtl/b64e_if.sv @@
// ----------------------------------------------------------------------------
// b64e_if
// Valid/ready channels for raw bytes in and encoded characters out.
// ----------------------------------------------------------------------------
interface b64e_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64e_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       run_end;
    logic       message_end;

    modport source (output valid, output out_char, output run_end, output message_end,
                    input ready);
    modport sink   (input valid, input out_char, input run_end, input message_end,
                    output ready);
endinterface

@@ rtl/b64e_front.sv @@
// ----------------------------------------------------------------------------
// b64e_front
// Gathers bytes into groups, tracks the line count and queues encoding jobs.
// ----------------------------------------------------------------------------
module b64e_front
    import b64e_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    b64e_in_if.sink          in_bytes,
    input  logic [GPL_W-1:0] groups_per_line,
    input  logic             queue_full,
    output logic             push,
    output job_t             push_job
);

    logic [7:0]       pend0_reg, pend0_next;
    logic [7:0]       pend1_reg, pend1_next;
    logic [1:0]       fill_reg, fill_next;
    logic [GPL_W-1:0] count_reg, count_next;
    logic             accept;
    logic [GPL_W-1:0] count_inc;
    logic             brk;

    assign in_bytes.ready = !queue_full;
    assign accept         = in_bytes.valid && !queue_full;
    assign count_inc      = count_reg + 1'b1;
    assign brk            = (groups_per_line != '0) && (count_inc >= groups_per_line);

    always_comb
    begin
        pend0_next = pend0_reg;
        pend1_next = pend1_reg;
        fill_next  = fill_reg;
        count_next = count_reg;
        push       = 1'b0;
        push_job   = '0;
        push_job.last = in_bytes.final_byte;
        if (accept)
        begin
            if (fill_reg == 2'd2)
            begin
                push          = 1'b1;
                push_job.b1   = pend0_reg;
                push_job.b2   = pend1_reg;
                push_job.b3   = in_bytes.data_byte;
                push_job.crlf = brk;
                fill_next     = 2'd0;
                count_next    = brk ? '0 : count_inc;
            end
            else if (!in_bytes.final_byte)
            begin
                if (fill_reg == 2'd0)
                begin
                    pend0_next = in_bytes.data_byte;
                end
                else
                begin
                    pend1_next = in_bytes.data_byte;
                end
                fill_next = fill_reg + 2'd1;
            end
            else if (fill_reg == 2'd0)
            begin
                push          = 1'b1;
                push_job.b1   = in_bytes.data_byte;
                push_job.pads = 2'd2;
            end
            else
            begin
                push          = 1'b1;
                push_job.b1   = pend0_reg;
                push_job.b2   = in_bytes.data_byte;
                push_job.pads = 2'd1;
            end
            // message done: next byte starts a fresh line
            if (in_bytes.final_byte)
            begin
                fill_next  = 2'd0;
                count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= 2'd0;
            count_reg <= '0;
        end
        else
        begin
            fill_reg  <= fill_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend0_reg <= pend0_next;
        pend1_reg <= pend1_next;
    end

endmodule

@@ rtl/b64e_fifo.sv @@
// ----------------------------------------------------------------------------
// b64e_fifo
// Small job queue between the front and the back.
// ----------------------------------------------------------------------------
module b64e_fifo
    import b64e_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic empty,
    output job_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == CNT_FULL);
    assign empty   = (cnt_reg == '0);
    assign head    = mem_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == PTR_LAST) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == PTR_LAST) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_job;
        end
    end

endmodule

@@ rtl/b64e_back.sv @@
// ----------------------------------------------------------------------------
// b64e_back
// Steps through a queued job one character per cycle into the output register while the sink is ready.
// ----------------------------------------------------------------------------
module b64e_back
    import b64e_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      job_empty,
    input  job_t      job,
    output logic      pop,
    b64e_out_if.source out_chars
);

    logic [2:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] char_reg;
    logic       run_end_reg;
    logic       msg_end_reg;
    logic       advance;
    logic       last_char;
    logic [5:0] sextet;
    logic [7:0] char_sel;

    assign out_chars.valid       = valid_reg;
    assign out_chars.out_char    = char_reg;
    assign out_chars.run_end     = run_end_reg;
    assign out_chars.message_end = msg_end_reg;

    assign advance   = !job_empty && (!valid_reg || out_chars.ready);
    assign last_char = (idx_reg == (job.crlf ? 3'd5 : 3'd3));
    assign pop       = advance && last_char;

    always_comb
    begin
        case (idx_reg)
            3'd0:    sextet = job.b1[7:2];
            3'd1:    sextet = {job.b1[1:0], job.b2[7:4]};
            3'd2:    sextet = {job.b2[3:0], job.b3[7:6]};
            3'd3:    sextet = job.b3[5:0];
            default: sextet = '0;
        endcase
    end

    always_comb
    begin
        if (idx_reg == 3'd4)
        begin
            char_sel = CHAR_CR;
        end
        else if (idx_reg == 3'd5)
        begin
            char_sel = CHAR_LF;
        end
        else if (idx_reg >= (3'd4 - {1'b0, job.pads}))
        begin
            char_sel = CHAR_PAD;
        end
        else
        begin
            char_sel = b64e_char(sextet);
        end
    end

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (advance)
        begin
            idx_next   = last_char ? 3'd0 : idx_reg + 3'd1;
            valid_next = 1'b1;
        end
        else if (out_chars.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            char_reg    <= char_sel;
            run_end_reg <= last_char;
            msg_end_reg <= last_char && job.last;
        end
    end

endmodule

@@ rtl/base64_encoder_line_wrap.sv @@
// ----------------------------------------------------------------------------
// base64_encoder_line_wrap
// Streaming Base64 encoder with CR LF after a programmable number of groups.
// ----------------------------------------------------------------------------
//  channel     dir   payload                             transaction
//  in_bytes    in    data_byte[7:0], final_byte          valid && ready
//  out_chars   out   out_char[7:0], run_end, message_end valid && ready
//  apb         in    groups_per_line at 0x0              psel && penable
//
//  a byte is taken whenever the job queue has room
//  a byte that completes a group yields 4 or 6 characters, a final partial
//  group 4; the back end sends one character per cycle from its output
//  register while the sink is ready
//  a taken byte's job is written into the queue, then its first character into the output register
//  reset: async, groups_per_line back to 19, queue and counts cleared
// ----------------------------------------------------------------------------
module base64_encoder_line_wrap
    import b64e_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    b64e_in_if.sink               in_bytes,
    b64e_out_if.source            out_chars,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [GPL_W-1:0] gpl_reg, gpl_next;
    logic             cfg_wr;
    logic             push;
    job_t             push_job;
    logic             pop;
    logic             q_full;
    logic             q_empty;
    job_t             head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
                    && (paddr[2] == REG_GROUPS_PER_LINE);
    assign gpl_next = cfg_wr ? pwdata[GPL_W-1:0] : gpl_reg;
    assign prdata = (paddr[2] == REG_GROUPS_PER_LINE)
                    ? {{(CFG_DATA_W-GPL_W){1'b0}}, gpl_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gpl_reg <= GPL_RESET;
        end
        else
        begin
            gpl_reg <= gpl_next;
        end
    end

    b64e_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_bytes        (in_bytes),
        .groups_per_line (gpl_reg),
        .queue_full      (q_full),
        .push            (push),
        .push_job        (push_job)
    );

    b64e_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (head)
    );

    b64e_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (q_empty),
        .job       (head),
        .pop       (pop),
        .out_chars (out_chars)
    );

endmodule

@@ rtl/b64e_checker.sv @@
// ----------------------------------------------------------------------------
// b64e_checker
// Port-level checks on the encoder output stream.
// ----------------------------------------------------------------------------
module b64e_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_char,
    input logic       run_end,
    input logic       message_end
);

    localparam logic [7:0] CR = 8'd13;

    // stalled character stays offered
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output valid dropped while stalled");

    a_char_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_char))
        else $error("output character changed while stalled");

    // end of message is always the end of a run
    a_msg_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && message_end |-> run_end)
        else $error("message_end without run_end");

    // CR is never the last character of a run
    a_cr_mid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_char == CR) |-> !run_end)
        else $error("run ended on CR");

endmodule

bind base64_encoder_line_wrap b64e_checker u_b64e_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_chars.valid),
    .out_ready   (out_chars.ready),
    .out_char    (out_chars.out_char),
    .run_end     (out_chars.run_end),
    .message_end (out_chars.message_end)
);

@@ verif/tb_base64_encoder_line_wrap.sv @@
// ----------------------------------------------------------------------------
// tb_base64_encoder_line_wrap
// Self-checking bench for the streaming Base64 encoder. Raw bytes go in with
// random burst gaps and the character sink stalls on its own pattern. Each
// accepted byte is run through a local encoder that holds its own pending
// bytes, line count and line limit, and every character that comes out is
// matched against the oldest predicted one. The line limit is reprogrammed
// between phases: default, one group per line, breaks disabled, the maximum
// and a limit lowered in the middle of a line.
// ----------------------------------------------------------------------------
module tb_base64_encoder_line_wrap;

    import b64e_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_ADDR_W-1:0] ADDR_LINE_LIMIT = {REG_GROUPS_PER_LINE, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] ADDR_UNUSED     = {~REG_GROUPS_PER_LINE, 2'b00};
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 200;
    localparam int SETTLE      = 6;

    typedef struct packed {
        logic [7:0] ch;
        logic       run_end;
        logic       message_end;
    } enc_char_t;

    typedef struct {
        logic [7:0] b;
        logic       last;
        string      known;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    b64e_in_if  in_if();
    b64e_out_if out_if();

    base64_encoder_line_wrap DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_bytes  (in_if),
        .out_chars (out_if),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // local encoder state
    string      b64_alphabet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    logic [5:0] line_limit;
    logic [7:0] held [2];
    int         held_n;
    logic [5:0] groups_on_line;
    enc_char_t  step_chars [$];
    enc_char_t  encoded_q [$];

    int   fail_count;
    int   msg_left;
    int   burst_left;
    logic hold_req;

    // expected text typed in where it is obvious, empty means use the encoder
    dir_row_t directed_rows [19] = '{
        '{8'h00, 1'b1, "AA=="},
        '{8'hFF, 1'b1, "/w=="},
        '{8'h00, 1'b0, ""},
        '{8'h00, 1'b1, "AAA="},
        '{8'hFF, 1'b0, ""},
        '{8'hFF, 1'b1, "//8="},
        '{8'h00, 1'b0, ""},
        '{8'h00, 1'b0, ""},
        '{8'h00, 1'b1, "AAAA"},
        '{8'hFF, 1'b0, ""},
        '{8'hFF, 1'b0, ""},
        '{8'hFF, 1'b0, "////"},
        '{8'h4D, 1'b0, ""},
        '{8'h61, 1'b0, ""},
        '{8'h6E, 1'b1, "TWFu"},
        '{8'hFB, 1'b0, ""},
        '{8'hEF, 1'b0, ""},
        '{8'hBE, 1'b1, "++++"},
        '{8'h01, 1'b1, "AQ=="}
    };

    function void push_char(input logic [7:0] c);
        enc_char_t e;
        e = '{c, 1'b0, 1'b0};
        step_chars = {step_chars, e};
    endfunction

    function void push_sextet(input logic [5:0] v);
        push_char(b64_alphabet[int'(v)]);
    endfunction

    function void mark_ends(input logic last);
        step_chars[step_chars.size()-1].run_end     = 1'b1;
        step_chars[step_chars.size()-1].message_end = last;
    endfunction

    // characters caused by one byte, left in step_chars
    function void encode_byte(input logic [7:0] b, input logic last);
        step_chars = {};
        if (held_n == 2)
        begin
            push_sextet(held[0][7:2]);
            push_sextet({held[0][1:0], held[1][7:4]});
            push_sextet({held[1][3:0], b[7:6]});
            push_sextet(b[5:0]);
            groups_on_line = groups_on_line + 6'd1;
            if (line_limit != 6'd0 && groups_on_line >= line_limit)
            begin
                push_char(CHAR_CR);
                push_char(CHAR_LF);
                groups_on_line = '0;
            end
            held_n = 0;
        end
        else if (!last)
        begin
            held[held_n] = b;
            held_n++;
            return;
        end
        else if (held_n == 0)
        begin
            push_sextet(b[7:2]);
            push_sextet({b[1:0], 4'b0000});
            push_char(CHAR_PAD);
            push_char(CHAR_PAD);
        end
        else
        begin
            push_sextet(held[0][7:2]);
            push_sextet({held[0][1:0], b[7:4]});
            push_sextet({b[3:0], 2'b00});
            push_char(CHAR_PAD);
        end
        mark_ends(last);
        if (last)
        begin
            held[0]        = '0;
            held[1]        = '0;
            held_n         = 0;
            groups_on_line = '0;
        end
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_byte(input logic [7:0] b, input logic last, input string known);
        int gap;
        @(negedge clk);
        in_if.valid      <= 1'b1;
        in_if.data_byte  <= b;
        in_if.final_byte <= last;
        do @(posedge clk); while (!in_if.ready);
        encode_byte(b, last);
        if (known.len() > 0)
        begin
            step_chars = {};
            for (int i = 0; i < known.len(); i++)
                push_char(known[i]);
            mark_ends(last);
        end
        encoded_q = {encoded_q, step_chars};
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                in_if.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    task automatic send_random(input int count);
        logic [7:0] b;
        for (int i = 0; i < count; i++)
        begin
            if (msg_left == 0)
                msg_left = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                      : $urandom_range(1, 12);
            if ($urandom_range(0, 9) == 0)
                b = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
            else
                b = 8'($urandom_range(0, 255));
            send_byte(b, msg_left == 1, "");
            msg_left--;
        end
    endtask

    // stop offering bytes and let every predicted character come out
    task automatic drain();
        @(negedge clk);
        in_if.valid <= 1'b0;
        while (encoded_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // write one register, then read the line limit back
    task automatic set_line_limit(input logic [CFG_ADDR_W-1:0] addr, input logic [5:0] value);
        logic [CFG_DATA_W-1:0] word;
        word = $urandom;
        word[GPL_W-1:0] = value;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == ADDR_LINE_LIMIT)
            line_limit = value;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_LINE_LIMIT;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== {{(CFG_DATA_W-GPL_W){1'b0}}, line_limit})
        begin
            $error("prdata: expected 0x%08h, got 0x%08h",
                   {{(CFG_DATA_W-GPL_W){1'b0}}, line_limit}, prdata);
            fail_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // character sink: stall patterns plus one long hold on request
    initial
    begin : receiver
        int unsigned cyc;
        int unsigned hold_left;
        int unsigned mode;
        logic [31:0] mask;
        logic        hold_seen;
        cyc       = 0;
        hold_left = 0;
        mode      = 0;
        mask      = '1;
        hold_seen = 1'b0;
        out_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            cyc++;
            if (hold_req && !hold_seen)
            begin
                hold_seen = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (cyc % 96 == 0)
            begin
                mode = $urandom_range(0, 2);
                mask = $urandom;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_if.ready <= 1'b0;
            end
            else if (mode == 0)
                out_if.ready <= 1'b1;
            else if (mode == 1)
                out_if.ready <= 1'($urandom_range(0, 1));
            else
                out_if.ready <= mask[cyc[4:0]];
        end
    end

    always @(posedge clk)
    begin : check_chars
        enc_char_t want;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            if (encoded_q.size() == 0)
            begin
                $error("out_char: expected nothing, got 0x%02h", out_if.out_char);
                fail_count++;
            end
            else
            begin
                want = encoded_q.pop_front();
                if (out_if.out_char !== want.ch)
                begin
                    $error("out_char: expected 0x%02h, got 0x%02h", want.ch, out_if.out_char);
                    fail_count++;
                end
                if (out_if.run_end !== want.run_end)
                begin
                    $error("run_end: expected %0b, got %0b", want.run_end, out_if.run_end);
                    fail_count++;
                end
                if (out_if.message_end !== want.message_end)
                begin
                    $error("message_end: expected %0b, got %0b",
                           want.message_end, out_if.message_end);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel)
                quiet = 0;
            else
                quiet++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        rst_n            = 1'b0;
        in_if.valid      = 1'b0;
        in_if.data_byte  = '0;
        in_if.final_byte = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        hold_req         = 1'b0;
        fail_count       = 0;
        msg_left         = 0;
        burst_left       = 0;
        line_limit       = GPL_RESET;
        held[0]          = '0;
        held[1]          = '0;
        held_n           = 0;
        groups_on_line   = '0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_byte(directed_rows[i].b, directed_rows[i].last, directed_rows[i].known);
        drain();
        send_random(20);
        drain();

        // unmapped address must leave the limit alone
        set_line_limit(ADDR_UNUSED, 6'($urandom_range(0, 63)));
        set_line_limit(ADDR_LINE_LIMIT, 6'd1);
        hold_req = 1'b1;
        send_random(40);
        drain();

        // breaks off, one long message builds up a high group count
        set_line_limit(ADDR_LINE_LIMIT, 6'd0);
        msg_left = 250;
        send_random(180);
        drain();

        // same message crosses the maximum limit
        set_line_limit(ADDR_LINE_LIMIT, 6'd63);
        send_random(30);
        drain();

        // limit dropped below the running count mid-line
        set_line_limit(ADDR_LINE_LIMIT, 6'd2);
        send_random(40);
        drain();

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/b64e_pkg.sv
rtl/b64e_if.sv
rtl/b64e_front.sv
rtl/b64e_fifo.sv
rtl/b64e_back.sv
rtl/base64_encoder_line_wrap.sv
rtl/b64e_checker.sv
verif/tb_base64_encoder_line_wrap.sv
